### hw/rtl/two_way_set_assoc_cache_lookup_assert.svh
// ============================================================================
// Assertion macros for the two-way set-associative cache lookup
// Shared clocked assertion forms. Defining NO_ASSERTIONS removes them.
// ============================================================================
`ifndef TWO_WAY_SET_ASSOC_CACHE_LOOKUP_ASSERT_SVH
`define TWO_WAY_SET_ASSOC_CACHE_LOOKUP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define TSAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define TSAC_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TSAC_ASSERT(lbl, prop, msg)

`define TSAC_NEVER(lbl, cond, msg)

`endif

`endif

### hw/rtl/tsac_pkg.sv
// ============================================================================
// tsac_pkg
// Types and fixed constants shared by the cache lookup modules.
// ============================================================================
package tsac_pkg;

    localparam int ADDR_W = 14;
    localparam int CNT_W  = 32;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_LOOK  = 3'b100
    } back_state_t;

endpackage

### hw/rtl/tsac_front.sv
// ============================================================================
// tsac_front
// Splits each accepted address into set index and tag and queues the pair
// for the lookup engine in a two-entry queue.
// ============================================================================
module tsac_front
    import tsac_pkg::*;
#(
    parameter int SETS        = 128,
    parameter int TAG_BITS    = 5,
    parameter int OFFSET_BITS = 2,
    parameter int IDX_W       = $clog2(SETS)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ADDR_W-1:0]   address,
    output logic                q_valid,
    input  logic                q_pop,
    output logic [IDX_W-1:0]    q_set,
    output logic [TAG_BITS-1:0] q_tag
);

    localparam int QD    = 2;
    localparam int PTR_W = $clog2(QD);
    localparam int CNT_QW = $clog2(QD + 1);

    logic [IDX_W+ADDR_W-1:0]    set_wide;
    logic [TAG_BITS+ADDR_W-1:0] tag_wide;
    logic [IDX_W-1:0]           set_raw;
    logic [IDX_W-1:0]           set_mod;
    logic [TAG_BITS-1:0]        tag_cur;
    logic                       push;

    logic [IDX_W-1:0]    set_q_reg [QD];
    logic [TAG_BITS-1:0] tag_q_reg [QD];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_QW-1:0]   count_reg;
    logic [CNT_QW-1:0]   count_next;

    always_comb
    begin
        set_wide = (IDX_W + ADDR_W)'(address) >> OFFSET_BITS;
        tag_wide = (TAG_BITS + ADDR_W)'(address) >> (OFFSET_BITS + IDX_W);
        set_raw  = set_wide[IDX_W-1:0];
        tag_cur  = tag_wide[TAG_BITS-1:0];
        if ({1'b0, set_raw} >= (IDX_W + 1)'(SETS))
        begin
            set_mod = set_raw - IDX_W'(SETS);
        end
        else
        begin
            set_mod = set_raw;
        end
    end

    assign in_stall = (count_reg == CNT_QW'(QD));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_set    = set_q_reg[rd_ptr_reg];
    assign q_tag    = tag_q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QD - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QD - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            set_q_reg[wr_ptr_reg] <= set_mod;
            tag_q_reg[wr_ptr_reg] <= tag_cur;
        end
    end

endmodule

### hw/rtl/tsac_back.sv
// ============================================================================
// tsac_back
// Lookup engine: reads a set row from the tag memory, compares both ways,
// refills on a miss, keeps the saturating counters and holds the result.
// ============================================================================
`include "two_way_set_assoc_cache_lookup_assert.svh"

module tsac_back
    import tsac_pkg::*;
#(
    parameter int SETS     = 128,
    parameter int TAG_BITS = 5,
    parameter int IDX_W    = $clog2(SETS)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    output logic                q_pop,
    input  logic [IDX_W-1:0]    q_set,
    input  logic [TAG_BITS-1:0] q_tag,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                hit,
    output logic                way,
    output logic [CNT_W-1:0]    hit_total,
    output logic [CNT_W-1:0]    miss_total
);

    localparam int ROW_W  = 2 * TAG_BITS + 3;
    localparam int T0_LO  = 0;
    localparam int T1_LO  = TAG_BITS;
    localparam int V0_BIT = 2 * TAG_BITS;
    localparam int V1_BIT = 2 * TAG_BITS + 1;
    localparam int VC_BIT = 2 * TAG_BITS + 2;

    logic [ROW_W-1:0] mem [SETS];
    logic [ROW_W-1:0] rdata_reg;
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [ROW_W-1:0] wr_data;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [IDX_W-1:0]    clr_cnt_reg;
    logic [IDX_W-1:0]    clr_cnt_next;
    logic [IDX_W-1:0]    set_reg;
    logic [TAG_BITS-1:0] tag_reg;

    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_hit_reg;
    logic             out_way_reg;

    logic                v0;
    logic                v1;
    logic [TAG_BITS-1:0] t0;
    logic [TAG_BITS-1:0] t1;
    logic                hit0;
    logic                hit1;
    logic                lk_hit;
    logic                lk_way;
    logic                fire;
    logic [ROW_W-1:0]    fill_row;

    always_comb
    begin
        v0     = rdata_reg[V0_BIT];
        v1     = rdata_reg[V1_BIT];
        t0     = rdata_reg[T0_LO +: TAG_BITS];
        t1     = rdata_reg[T1_LO +: TAG_BITS];
        hit0   = v0 && (t0 == tag_reg);
        hit1   = v1 && (t1 == tag_reg);
        lk_hit = hit0 || hit1;
        if (hit0)
        begin
            lk_way = 1'b0;
        end
        else if (hit1)
        begin
            lk_way = 1'b1;
        end
        else if (v0 && v1)
        begin
            lk_way = rdata_reg[VC_BIT];
        end
        else
        begin
            lk_way = v0;
        end
        fill_row         = rdata_reg;
        fill_row[VC_BIT] = !lk_way;
        if (lk_way)
        begin
            fill_row[T1_LO +: TAG_BITS] = tag_reg;
            fill_row[V1_BIT]            = 1'b1;
        end
        else
        begin
            fill_row[T0_LO +: TAG_BITS] = tag_reg;
            fill_row[V0_BIT]            = 1'b1;
        end
    end

    assign q_pop = (state_reg == ST_IDLE) && q_valid;
    assign rd_en = q_pop;
    assign fire  = (state_reg == ST_LOOK) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        hit_cnt_next   = hit_cnt_reg;
        miss_cnt_next  = miss_cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        wr_en          = 1'b0;
        wr_addr        = set_reg;
        wr_data        = fill_row;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == IDX_W'(SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                if (fire)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    if (lk_hit)
                    begin
                        if (hit_cnt_reg != CNT_MAX)
                        begin
                            hit_cnt_next = hit_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        if (miss_cnt_reg != CNT_MAX)
                        begin
                            miss_cnt_next = miss_cnt_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            set_reg <= q_set;
            tag_reg <= q_tag;
        end
        if (fire)
        begin
            out_hit_reg <= lk_hit;
            out_way_reg <= lk_way;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[q_set];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit        = out_hit_reg;
    assign way        = out_way_reg;
    assign hit_total  = hit_cnt_reg;
    assign miss_total = miss_cnt_reg;

    `TSAC_NEVER(a_pop_during_clear, (state_reg == ST_CLEAR) && q_pop, "Queue popped during clear.")
    `TSAC_ASSERT(a_miss_writes, (fire && !lk_hit) |-> wr_en, "Miss did not refill a way.")
    `TSAC_ASSERT(a_fill_way0_first, (fire && !lk_hit && !v0) |-> !lk_way, "Invalid way 0 skipped.")
    `TSAC_ASSERT(a_one_count_step, (hit_cnt_reg != $past(hit_cnt_reg)) |-> (miss_cnt_reg == $past(miss_cnt_reg)), "Hit and miss counts advanced together.")

endmodule

### hw/rtl/two_way_set_assoc_cache_lookup.sv
// ============================================================================
// two_way_set_assoc_cache_lookup
// Tag store of a two-way set-associative cache with FIFO replacement.
// ============================================================================
// The input channel (in_valid, in_stall, address) carries one address per
// transaction. The output channel (out_valid, out_stall, hit, way, hit_total,
// miss_total) returns exactly one result per address, in order.
// An accepted address is written into a two-entry queue at the accepting edge.
// The lookup engine then first reads the set row of each address from the
// single-port tag memory, then compares both ways, refills on a miss and
// loads the result register. It takes no new address from the queue until
// it is through with the last one, because of the read-modify-write of
// that memory.
// After reset the engine clears the valid bits of all SETS rows, one row a
// cycle, so no result comes before the clear is done; addresses are still
// taken until the queue is full. Counters reset to zero.
// While out_stall is high a result that is shown holds, the engine waits with
// its next row, and in_stall rises once the queue is full.
// ============================================================================
module two_way_set_assoc_cache_lookup
    import tsac_pkg::*;
#(
    parameter int SETS        = 128,
    parameter int TAG_BITS    = 5,
    parameter int OFFSET_BITS = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [ADDR_W-1:0] address,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              hit,
    output logic              way,
    output logic [CNT_W-1:0]  hit_total,
    output logic [CNT_W-1:0]  miss_total
);

    localparam int IDX_W = $clog2(SETS);

    logic                q_valid;
    logic                q_pop;
    logic [IDX_W-1:0]    q_set;
    logic [TAG_BITS-1:0] q_tag;

    tsac_front #(
        .SETS        (SETS),
        .TAG_BITS    (TAG_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .IDX_W       (IDX_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .address  (address),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_set    (q_set),
        .q_tag    (q_tag)
    );

    tsac_back #(
        .SETS     (SETS),
        .TAG_BITS (TAG_BITS),
        .IDX_W    (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_set      (q_set),
        .q_tag      (q_tag),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit),
        .way        (way),
        .hit_total  (hit_total),
        .miss_total (miss_total)
    );

endmodule

### tb/sv/tb_top.sv
// ============================================================================
// Testbench for the two-way set-associative cache lookup
// A short directed sequence and then random addresses are driven into the
// block. Most random addresses fall in a few busy sets so that hits, fills
// and FIFO refills all occur. Each result is compared field by field with
// a local model of the tag store, valid bits, victim bits and counters.
// ============================================================================
module tb_top;
    import tsac_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int OFS_LO     = 2;
    localparam int SET_W      = 7;
    localparam int TAG_W      = 5;
    localparam int NUM_SETS   = 128;
    localparam int RAND_ITEMS = 800;
    localparam int CALM_TAIL  = 100;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 80;
    localparam int CYCLE_CAP  = 200000;

    typedef struct packed {
        logic              drain;
        logic [ADDR_W-1:0] addr;
    } addr_item_t;

    typedef struct packed {
        logic             hit;
        logic             way;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
    } lookup_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [ADDR_W-1:0] address = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              hit;
    logic              way;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;

    addr_item_t     addr_pending[$];
    lookup_result_t result_due[$];

    logic [TAG_W-1:0] tag_mem [0:2*NUM_SETS-1];
    logic             valid_mem [0:2*NUM_SETS-1];
    logic             victim_mem [0:NUM_SETS-1];
    logic [CNT_W-1:0] hit_count = '0;
    logic [CNT_W-1:0] miss_count = '0;

    logic in_taken = 1'b0;
    logic long_hold = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   taken_total = 0;
    int   err_count = 0;
    int   cycle_count = 0;
    int   send_gap = 0;
    int   recv_gap = 0;

    two_way_set_assoc_cache_lookup u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .address    (address),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit),
        .way        (way),
        .hit_total  (hit_total),
        .miss_total (miss_total)
    );

    always #2 clk = ~clk;

    task automatic predict_lookup(input logic [ADDR_W-1:0] a);
        logic [SET_W-1:0] set_idx;
        logic [TAG_W-1:0] tag;
        logic             v0;
        logic             v1;
        lookup_result_t   r;
        set_idx = a[OFS_LO +: SET_W];
        tag     = a[OFS_LO+SET_W +: TAG_W];
        v0      = valid_mem[{set_idx, 1'b0}];
        v1      = valid_mem[{set_idx, 1'b1}];
        r.hit   = 1'b0;
        r.way   = 1'b0;
        if (v0 && tag_mem[{set_idx, 1'b0}] == tag)
        begin
            r.hit = 1'b1;
        end
        else if (v1 && tag_mem[{set_idx, 1'b1}] == tag)
        begin
            r.hit = 1'b1;
            r.way = 1'b1;
        end
        if (r.hit)
        begin
            if (hit_count != CNT_MAX)
                hit_count = hit_count + 1'b1;
        end
        else
        begin
            if (miss_count != CNT_MAX)
                miss_count = miss_count + 1'b1;
            if (v0 && v1)
                r.way = victim_mem[set_idx];
            else
                r.way = v0;
            tag_mem[{set_idx, r.way}]   = tag;
            valid_mem[{set_idx, r.way}] = 1'b1;
            victim_mem[set_idx]         = ~r.way;
        end
        r.hits   = hit_count;
        r.misses = miss_count;
        result_due.push_back(r);
    endtask

    function automatic logic [ADDR_W-1:0] make_addr(input int tag, input int set_idx,
                                                    input int ofs);
        logic [ADDR_W-1:0] a;
        a = '0;
        a[OFS_LO+SET_W +: TAG_W] = tag[TAG_W-1:0];
        a[OFS_LO +: SET_W]       = set_idx[SET_W-1:0];
        a[OFS_LO-1:0]            = ofs[OFS_LO-1:0];
        return a;
    endfunction

    task automatic queue_addr(input logic [ADDR_W-1:0] a, input logic drain);
        addr_item_t it;
        it.addr  = a;
        it.drain = drain;
        addr_pending.push_back(it);
    endtask

    function automatic logic idling_allowed();
        return (addr_pending.size() >= CALM_TAIL) && ((cycle_count / 128) % 3 != 2);
    endfunction

    always @(posedge clk)
    begin : sample_proc
        lookup_result_t want;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                in_taken    = 1'b1;
                taken_total = taken_total + 1;
                predict_lookup(address);
            end
            if (out_valid && !out_stall)
            begin
                if (result_due.size() == 0)
                begin
                    err_count = err_count + 1;
                    $display("%0t: result with none expected: hit=%0b way=%0b", $time, hit, way);
                end
                else
                begin
                    want = result_due.pop_front();
                    if (hit !== want.hit)
                    begin
                        err_count = err_count + 1;
                        $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
                    end
                    if (way !== want.way)
                    begin
                        err_count = err_count + 1;
                        $display("%0t: way expected %0b actual %0b", $time, want.way, way);
                    end
                    if (hit_total !== want.hits)
                    begin
                        err_count = err_count + 1;
                        $display("%0t: hit_total expected %0d actual %0d", $time, want.hits,
                                 hit_total);
                    end
                    if (miss_total !== want.misses)
                    begin
                        err_count = err_count + 1;
                        $display("%0t: miss_total expected %0d actual %0d", $time,
                                 want.misses, miss_total);
                    end
                end
            end
        end
    end

    always @(negedge clk)
    begin : drive_proc
        logic              next_valid;
        logic [ADDR_W-1:0] next_addr;
        next_valid = in_valid;
        next_addr  = address;
        if (rst_n)
        begin
            if (in_valid && in_taken)
                next_valid = 1'b0;
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap = send_gap - 1;
                else if (addr_pending.size() > 0)
                begin
                    if (addr_pending[0].drain && result_due.size() != 0)
                        next_valid = 1'b0;
                    else if (idling_allowed() && !long_hold && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 14) - 1;
                    else
                    begin
                        next_valid = 1'b1;
                        next_addr  = addr_pending[0].addr;
                        void'(addr_pending.pop_front());
                    end
                end
            end
        end
        in_valid <= next_valid;
        address  <= next_addr;
    end

    always @(negedge clk)
    begin : recv_proc
        logic next_stall;
        next_stall = 1'b0;
        if (rst_n)
        begin
            if (long_hold)
                next_stall = 1'b1;
            else if (recv_gap > 0)
            begin
                recv_gap   = recv_gap - 1;
                next_stall = 1'b1;
            end
            else if (idling_allowed() && $urandom_range(0, 7) == 0)
            begin
                recv_gap   = $urandom_range(1, 14) - 1;
                next_stall = 1'b1;
            end
        end
        out_stall <= next_stall;
    end

    always @(negedge clk)
    begin : hold_proc
        if (!hold_done && taken_total >= HOLD_AT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN;
            long_hold <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            if (hold_left == 0)
                long_hold <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_CAP)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin : main_proc
        int busy_sets[4];
        int drain_at;
        for (int i = 0; i < 2 * NUM_SETS; i++)
            valid_mem[i] = 1'b0;

        queue_addr(make_addr(0, 0, 0), 1'b0);
        queue_addr(make_addr(0, 0, 0), 1'b0);
        queue_addr(make_addr(0, 0, 3), 1'b0);
        queue_addr(make_addr(1, 0, 0), 1'b0);
        queue_addr(make_addr(1, 0, 1), 1'b0);
        queue_addr(make_addr(2, 0, 2), 1'b0);
        queue_addr(make_addr(0, 0, 0), 1'b0);
        queue_addr(make_addr(1, 0, 0), 1'b0);
        queue_addr(make_addr(2, 0, 0), 1'b0);
        queue_addr(14'h3FFF, 1'b0);
        queue_addr(14'h3FFF, 1'b0);
        queue_addr(make_addr(31, 127, 0), 1'b0);
        queue_addr(make_addr(0, 127, 0), 1'b0);
        queue_addr(make_addr(31, 0, 0), 1'b0);
        queue_addr(make_addr(0, 1, 0), 1'b0);
        queue_addr(make_addr(0, 64, 0), 1'b0);
        queue_addr(make_addr(16, 64, 0), 1'b0);

        drain_at = $urandom_range(400, 600);
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 100 == 0)
                foreach (busy_sets[k])
                    busy_sets[k] = $urandom_range(0, NUM_SETS - 1);
            if ($urandom_range(0, 3) != 0)
                queue_addr(make_addr($urandom_range(0, 3), busy_sets[$urandom_range(0, 3)],
                                     $urandom_range(0, 3)), i == 0 || i == drain_at);
            else
                queue_addr(ADDR_W'($urandom_range(0, 16383)), i == 0 || i == drain_at);
        end

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (addr_pending.size() != 0 || in_valid)
            @(posedge clk);
        while (result_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
